FILE: src/mrts_pkg.sv
// ----------------------------------------------------------------------------
// mrts_pkg
// Shared widths, reset values, phase and register codes, and the beat
// types of the motor reversal test sequencer.
// ----------------------------------------------------------------------------
package mrts_pkg;

	// field widths
	localparam int unsigned TargetW  = 15;
	localparam int unsigned BandW    = 11;
	localparam int unsigned DwellW   = 16;
	localparam int unsigned SpeedW   = 16;
	localparam int unsigned TimeW    = 32;
	localparam int unsigned PhaseW   = 3;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;

	// band limits use two bits above the speed width to avoid wrap
	localparam int unsigned SpanW = SpeedW + 2;

	// register reset values
	localparam logic [TargetW-1:0] TargetReset = TargetW'(2500);
	localparam logic [BandW-1:0]   BandReset   = BandW'(30);
	localparam logic [DwellW-1:0]  DwellReset  = DwellW'(500);

	// test phases, coded as shown on the result beat
	typedef enum logic [PhaseW-1:0] {
		PH_STANDBY = 3'd0,
		PH_PRESSED = 3'd1,
		PH_CW      = 3'd2,
		PH_CCW     = 3'd3,
		PH_STOP    = 3'd4
	} phase_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_TARGET = 2'd0,
		REG_BAND   = 2'd1,
		REG_DWELL  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [TargetW-1:0] target_speed;
		logic [BandW-1:0]   speed_band;
		logic [DwellW-1:0]  dwell_ms;
	} cfg_t;

	typedef struct packed {
		logic                     button_rise;
		logic                     button_fall;
		logic signed [SpeedW-1:0] measured_speed;
		logic [TimeW-1:0]         now_ms;
	} item_t;

	typedef struct packed {
		phase_t                   test_phase;
		logic signed [SpeedW-1:0] speed_setpoint;
		logic                     controller_on;
		logic                     start_pulse;
		logic                     stop_pulse;
	} result_t;

	// window check status handed from the band unit to the sequencer
	typedef struct packed {
		logic in_band;
		logic reached;
	} band_stat_t;

endpackage

FILE: src/mrts_if.sv
// ----------------------------------------------------------------------------
// mrts_if
// Valid/ready channels of the sequencer: handler call beats, result beats
// and configuration writes.
// ----------------------------------------------------------------------------
interface mrts_item_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      button_rise;
	logic                                      button_fall;
	logic signed [mrts_pkg::SpeedW-1:0]        measured_speed;
	logic [mrts_pkg::TimeW-1:0]                now_ms;

	modport source (output valid, button_rise, button_fall, measured_speed, now_ms,
		input ready);
	modport sink (input valid, button_rise, button_fall, measured_speed, now_ms,
		output ready);
endinterface

interface mrts_result_if;
	logic                                      valid;
	logic                                      ready;
	logic [mrts_pkg::PhaseW-1:0]               test_phase;
	logic signed [mrts_pkg::SpeedW-1:0]        speed_setpoint;
	logic                                      controller_on;
	logic                                      start_pulse;
	logic                                      stop_pulse;

	modport source (output valid, test_phase, speed_setpoint, controller_on,
		start_pulse, stop_pulse, input ready);
	modport sink (input valid, test_phase, speed_setpoint, controller_on,
		start_pulse, stop_pulse, output ready);
endinterface

interface mrts_cfg_if;
	logic                                      valid;
	logic                                      ready;
	logic [mrts_pkg::CfgIdxW-1:0]              index;
	logic [mrts_pkg::CfgDataW-1:0]             data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/mrts_band.sv
// ----------------------------------------------------------------------------
// mrts_band
// Speed window compare around the setpoint and dwell time check.
// ----------------------------------------------------------------------------
module mrts_band (
	input  logic signed [mrts_pkg::SpeedW-1:0] setpoint,
	input  logic [mrts_pkg::BandW-1:0]         speed_band,
	input  logic [mrts_pkg::DwellW-1:0]        dwell_ms,
	input  logic [mrts_pkg::TimeW-1:0]         entry_time,
	input  logic signed [mrts_pkg::SpeedW-1:0] measured_speed,
	input  logic [mrts_pkg::TimeW-1:0]         now_ms,
	output mrts_pkg::band_stat_t               stat
);

	logic signed [mrts_pkg::SpanW-1:0] sp_x;
	logic signed [mrts_pkg::SpanW-1:0] band_x;
	logic signed [mrts_pkg::SpanW-1:0] spd_x;
	logic signed [mrts_pkg::SpanW-1:0] lo;
	logic signed [mrts_pkg::SpanW-1:0] hi;
	logic [mrts_pkg::TimeW-1:0]        elapsed;

	// form limits at full width
	assign sp_x   = mrts_pkg::SpanW'(setpoint);
	assign band_x = $signed(mrts_pkg::SpanW'(speed_band));
	assign spd_x  = mrts_pkg::SpanW'(measured_speed);
	assign lo     = sp_x - band_x;
	assign hi     = sp_x + band_x;

	// modular elapsed time since band entry
	assign elapsed = now_ms - entry_time;

	assign stat.in_band = (spd_x >= lo) && (spd_x <= hi);
	assign stat.reached = stat.in_band && (elapsed >= mrts_pkg::TimeW'(dwell_ms));

endmodule

FILE: src/mrts_fsm.sv
// ----------------------------------------------------------------------------
// mrts_fsm
// Test phase sequencer: holds phase, setpoint, band entry time and the
// controller enable, and forms the result of the current handler call.
// ----------------------------------------------------------------------------
module mrts_fsm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  mrts_pkg::item_t       item,
	input  mrts_pkg::cfg_t        cfg,
	output mrts_pkg::result_t     res
);

	mrts_pkg::phase_t                   phase_q;
	mrts_pkg::phase_t                   phase_d;
	logic signed [mrts_pkg::SpeedW-1:0] setpoint_q;
	logic signed [mrts_pkg::SpeedW-1:0] setpoint_d;
	logic [mrts_pkg::TimeW-1:0]         entry_q;
	logic [mrts_pkg::TimeW-1:0]         entry_d;
	logic                               enable_q;
	logic                               enable_d;
	logic                               start;
	logic                               stop;
	logic                               checking;
	mrts_pkg::band_stat_t               stat;

	// pick the setpoint of the running phase
	always_comb begin
		unique case (phase_q)
			mrts_pkg::PH_CW:   setpoint_d = mrts_pkg::SpeedW'(cfg.target_speed);
			mrts_pkg::PH_CCW:  setpoint_d = -mrts_pkg::SpeedW'(cfg.target_speed);
			mrts_pkg::PH_STOP: setpoint_d = '0;
			default:           setpoint_d = setpoint_q;
		endcase
	end

	mrts_band u_band (
		.setpoint       (setpoint_d),
		.speed_band     (cfg.speed_band),
		.dwell_ms       (cfg.dwell_ms),
		.entry_time     (entry_q),
		.measured_speed (item.measured_speed),
		.now_ms         (item.now_ms),
		.stat           (stat)
	);

	// next phase
	always_comb begin
		unique case (phase_q)
			mrts_pkg::PH_STANDBY: phase_d = item.button_rise ? mrts_pkg::PH_PRESSED : phase_q;
			mrts_pkg::PH_PRESSED: phase_d = item.button_fall ? mrts_pkg::PH_CW : phase_q;
			mrts_pkg::PH_CW:      phase_d = stat.reached ? mrts_pkg::PH_CCW : phase_q;
			mrts_pkg::PH_CCW:     phase_d = stat.reached ? mrts_pkg::PH_STOP : phase_q;
			mrts_pkg::PH_STOP:    phase_d = stat.reached ? mrts_pkg::PH_STANDBY : phase_q;
			default:              phase_d = mrts_pkg::PH_STANDBY;
		endcase
	end

	// pulses and controller enable
	always_comb begin
		start    = 1'b0;
		stop     = 1'b0;
		enable_d = enable_q;
		checking = 1'b0;
		unique case (phase_q)
			mrts_pkg::PH_STANDBY: begin
			end
			mrts_pkg::PH_PRESSED: begin
				if (item.button_fall) begin
					enable_d = 1'b1;
					start    = 1'b1;
				end
			end
			mrts_pkg::PH_CW, mrts_pkg::PH_CCW: begin
				checking = 1'b1;
			end
			mrts_pkg::PH_STOP: begin
				checking = 1'b1;
				if (stat.reached) begin
					enable_d = 1'b0;
					stop     = 1'b1;
				end
			end
			default: begin
				enable_d = 1'b0;
				stop     = 1'b1;
			end
		endcase
	end

	// reload band entry time while checking and the speed is outside the window
	assign entry_d = (checking && !stat.in_band) ? item.now_ms : entry_q;

	// commit state on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mrts_pkg::PH_STANDBY;
			setpoint_q <= '0;
			entry_q    <= '0;
			enable_q   <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_d;
			setpoint_q <= setpoint_d;
			entry_q    <= entry_d;
			enable_q   <= enable_d;
		end
	end

	assign res.test_phase     = phase_d;
	assign res.speed_setpoint = setpoint_d;
	assign res.controller_on  = enable_d;
	assign res.start_pulse    = start;
	assign res.stop_pulse     = stop;

endmodule

FILE: src/motor_reversal_test_sequencer_core.sv
// ----------------------------------------------------------------------------
// motor_reversal_test_sequencer_core
// Button driven clockwise / counter-clockwise / stop speed test sequencer.
// ----------------------------------------------------------------------------
// Each beat on item is one handler call and yields exactly one beat on
// result. The block takes one call per clock unless a waiting result
// stalls it: a call is registered on acceptance, evaluated from the input
// register by the window compare, the 32-bit elapsed time subtraction and
// the phase step, and the result sits in an output register; a new call
// is accepted while a finished result waits for its sink if the input
// register is empty. Throughput is set by the single state update per
// cycle in the phase sequencer. Configuration writes take effect for calls
// evaluated after them; cfg is always ready and indexes above two are ignored.
module motor_reversal_test_sequencer_core (
	input  logic          clk,
	input  logic          arst_n,
	mrts_item_if.sink     item,
	mrts_result_if.source result,
	mrts_cfg_if.sink      cfg
);

	mrts_pkg::cfg_t    cfg_q;
	mrts_pkg::item_t   item_s1;
	logic              valid_s1;
	mrts_pkg::result_t res_d;
	mrts_pkg::result_t res_q;
	logic              res_valid_q;
	logic              advance;
	logic              item_take;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed <= mrts_pkg::TargetReset;
			cfg_q.speed_band   <= mrts_pkg::BandReset;
			cfg_q.dwell_ms     <= mrts_pkg::DwellReset;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mrts_pkg::REG_TARGET: cfg_q.target_speed <= cfg.data[mrts_pkg::TargetW-1:0];
				mrts_pkg::REG_BAND:   cfg_q.speed_band   <= cfg.data[mrts_pkg::BandW-1:0];
				mrts_pkg::REG_DWELL:  cfg_q.dwell_ms     <= cfg.data[mrts_pkg::DwellW-1:0];
				default: begin
				end
			endcase
		end
	end

	// move a call forward when the result register is free or draining
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign item_take  = item.valid && item.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1.button_rise    <= item.button_rise;
			item_s1.button_fall    <= item.button_fall;
			item_s1.measured_speed <= item.measured_speed;
			item_s1.now_ms         <= item.now_ms;
		end
	end

	mrts_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.test_phase     = res_q.test_phase;
	assign result.speed_setpoint = res_q.speed_setpoint;
	assign result.controller_on  = res_q.controller_on;
	assign result.start_pulse    = res_q.start_pulse;
	assign result.stop_pulse     = res_q.stop_pulse;

endmodule

FILE: src/mrts_checker.sv
// ----------------------------------------------------------------------------
// mrts_checker
// Port level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
module mrts_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [mrts_pkg::PhaseW-1:0]        test_phase,
	input logic signed [mrts_pkg::SpeedW-1:0] speed_setpoint,
	input logic                               controller_on,
	input logic                               start_pulse,
	input logic                               stop_pulse
);

	// start lands in clockwise with the controller on
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_pulse |->
			test_phase == mrts_pkg::PH_CW && controller_on && !stop_pulse)
		else $error("start beat not in clockwise phase with controller on");

	// stop lands in standby with the controller off
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stop_pulse |->
			test_phase == mrts_pkg::PH_STANDBY && !controller_on)
		else $error("stop beat not in standby with controller off");

	// idle phases drive no speed and keep the controller off
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (test_phase == mrts_pkg::PH_STANDBY ||
			test_phase == mrts_pkg::PH_PRESSED) |->
			speed_setpoint == '0 && !controller_on)
		else $error("setpoint or controller active outside the test");

	// running phases keep the controller on
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (test_phase == mrts_pkg::PH_CW || test_phase == mrts_pkg::PH_CCW) |->
			controller_on)
		else $error("controller off during a running phase");

	// stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(test_phase) && $stable(speed_setpoint))
		else $error("stalled result beat changed");

endmodule

bind motor_reversal_test_sequencer_core mrts_checker u_mrts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.test_phase     (result.test_phase),
	.speed_setpoint (result.speed_setpoint),
	.controller_on  (result.controller_on),
	.start_pulse    (result.start_pulse),
	.stop_pulse     (result.stop_pulse)
);
